// File: rtl/bis_pkg.sv
// Shared types and constants for the bilinear image scaler.
package bis_pkg;

    localparam int COORD_W = 12;
    localparam int PIX_W   = 8;
    localparam int SIZE_W  = 13;
    localparam int INV_W   = 21;
    localparam int IDX_W   = 3;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    typedef enum logic [IDX_W-1:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_OUT_WIDTH  = 3'd2,
        REG_OUT_HEIGHT = 3'd3,
        REG_INV_SCALE  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [8:0]        src_width;
        logic [8:0]        src_height;
        logic [SIZE_W-1:0] out_width;
        logic [SIZE_W-1:0] out_height;
        logic [INV_W-1:0]  inv_scale;
    } t_cfg;

    // flag: range error on a request, in-store on a load
    typedef struct packed {
        logic               is_req;
        logic               flag;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   pix;
    } t_item;

endpackage

// File: rtl/bis_front.sv
// Front end: accepts words and classifies them for the back end.
module bis_front #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_req_type,
    input  logic [bis_pkg::COORD_W-1:0]   i_pix_row,
    input  logic [bis_pkg::COORD_W-1:0]   i_pix_col,
    input  logic [bis_pkg::PIX_W-1:0]     i_pixel_in,
    input  bis_pkg::t_cfg                 i_cfg,
    input  logic                          i_full,
    output logic                          o_push,
    output bis_pkg::t_item                o_item,
    output logic                          o_busy
);
    import bis_pkg::*;

    logic  r_valid, n_valid;
    t_item r_item;
    t_item n_item;
    logic  row13_ok, col13_ok;

    assign o_push = r_valid && !i_full;
    assign o_busy = r_valid && i_full;
    assign o_item = r_item;

    assign row13_ok = {1'b0, i_pix_row} < SIZE_W'(MAX_SRC_HEIGHT);
    assign col13_ok = {1'b0, i_pix_col} < SIZE_W'(MAX_SRC_WIDTH);

    always_comb begin
        n_item.is_req = i_req_type;
        n_item.row    = i_pix_row;
        n_item.col    = i_pix_col;
        n_item.pix    = i_pixel_in;
        if (i_req_type == REQ_PIXEL) begin
            n_item.flag = ({1'b0, i_pix_row} >= i_cfg.out_height) ||
                          ({1'b0, i_pix_col} >= i_cfg.out_width);
        end else begin
            n_item.flag = row13_ok && col13_ok;
        end
        if (i_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_accept) begin
            r_item <= n_item;
        end
    end

endmodule

// File: rtl/bis_fifo.sv
// Two-entry queue between front and back end.
module bis_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bis_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output bis_pkg::t_item o_item
);
    import bis_pkg::*;

    t_item      r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count, n_count;
    logic       pop;

    assign pop     = r_count != 2'd0;
    assign o_valid = pop;
    assign o_full  = r_count == 2'd2;
    assign o_item  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count + 2'(i_push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

// File: rtl/bis_back.sv
// Back end: frame store banks and the interpolation pipeline.
module bis_back #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int FRAC_BITS      = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  bis_pkg::t_item              i_item,
    input  bis_pkg::t_cfg               i_cfg,
    output logic                        o_done,
    output logic [bis_pkg::PIX_W-1:0]   o_interp_pixel,
    output logic [bis_pkg::COORD_W-1:0] o_res_row,
    output logic [bis_pkg::COORD_W-1:0] o_res_col,
    output logic                        o_range_error
);
    import bis_pkg::*;

    localparam int POS_W = COORD_W + INV_W;
    localparam int IP_W  = POS_W - FRAC_BITS;
    localparam int CMP_W = (IP_W > SIZE_W) ? IP_W : SIZE_W;
    localparam int F1_W  = FRAC_BITS + 1;
    localparam int W_W   = 2 * F1_W;
    localparam int PR_W  = W_W + PIX_W;
    localparam int SUM_W = PR_W + 2;
    localparam int HW    = (MAX_SRC_WIDTH + 1) / 2;
    localparam int HH    = (MAX_SRC_HEIGHT + 1) / 2;
    localparam int BD    = HW * HH;
    localparam int BA_W  = $clog2(BD);
    localparam logic [F1_W-1:0] ONE = F1_W'(1) << FRAC_BITS;

    // stage 1
    logic             r_v1;
    t_item            r_it1;
    logic [POS_W-1:0] r_posy, r_posx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_it1  <= i_item;
        r_posy <= POS_W'(i_item.row) * POS_W'(i_cfg.inv_scale);
        r_posx <= POS_W'(i_item.col) * POS_W'(i_cfg.inv_scale);
    end

    logic [SIZE_W-1:0]    sw, sh, iy, ix, by, bx, by1, bx1;
    logic [CMP_W-1:0]     ipy, ipx;
    logic [FRAC_BITS-1:0] fy0, fx0;
    logic [F1_W-1:0]      fy, fx;
    logic                 exact;
    logic [BA_W-1:0]      raddr [4];
    logic [BA_W-1:0]      waddr;
    logic [1:0]           wbank;
    logic                 we;

    always_comb begin
        if (i_cfg.src_width < 9'd2) begin
            sw = SIZE_W'(2);
        end else if ({4'b0, i_cfg.src_width} > SIZE_W'(MAX_SRC_WIDTH)) begin
            sw = SIZE_W'(MAX_SRC_WIDTH);
        end else begin
            sw = {4'b0, i_cfg.src_width};
        end
        if (i_cfg.src_height < 9'd2) begin
            sh = SIZE_W'(2);
        end else if ({4'b0, i_cfg.src_height} > SIZE_W'(MAX_SRC_HEIGHT)) begin
            sh = SIZE_W'(MAX_SRC_HEIGHT);
        end else begin
            sh = {4'b0, i_cfg.src_height};
        end
        ipy = CMP_W'(r_posy[POS_W-1:FRAC_BITS]);
        ipx = CMP_W'(r_posx[POS_W-1:FRAC_BITS]);
        fy0 = r_posy[FRAC_BITS-1:0];
        fx0 = r_posx[FRAC_BITS-1:0];
        iy  = (ipy > CMP_W'(sh - 1'b1)) ? sh - 1'b1 : SIZE_W'(ipy);
        ix  = (ipx > CMP_W'(sw - 1'b1)) ? sw - 1'b1 : SIZE_W'(ipx);
        exact = (fy0 == '0) && (fx0 == '0);
        by  = iy;
        bx  = ix;
        fy  = {1'b0, fy0};
        fx  = {1'b0, fx0};
        if (!exact && iy == sh - 1'b1) begin
            fy = ONE;
            by = sh - SIZE_W'(2);
        end
        if (!exact && ix == sw - 1'b1) begin
            fx = ONE;
            bx = sw - SIZE_W'(2);
        end
        by1 = by + 1'b1;
        bx1 = bx + 1'b1;
        for (int b = 0; b < 4; b++) begin
            logic [SIZE_W-2:0] lr, lc;
            lr = (by[0] == b[1]) ? by[SIZE_W-1:1] : by1[SIZE_W-1:1];
            lc = (bx[0] == b[0]) ? bx[SIZE_W-1:1] : bx1[SIZE_W-1:1];
            if (32'(lr) > 32'(HH - 1)) begin
                lr = (SIZE_W-1)'(HH - 1);
            end
            if (32'(lc) > 32'(HW - 1)) begin
                lc = (SIZE_W-1)'(HW - 1);
            end
            raddr[b] = BA_W'(32'(lr) * 32'(HW) + 32'(lc));
        end
        wbank = {r_it1.row[0], r_it1.col[0]};
        waddr = BA_W'(32'(r_it1.row[COORD_W-1:1]) * 32'(HW)
                      + 32'(r_it1.col[COORD_W-1:1]));
        we    = r_v1 && (r_it1.is_req == REQ_LOAD) && r_it1.flag;
    end

    logic [PIX_W-1:0] q [4];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [PIX_W-1:0] mem [BD];
        always_ff @(posedge i_clk) begin
            if (we && wbank == 2'(b)) begin
                mem[waddr] <= r_it1.pix;
            end
            q[b] <= mem[raddr[b]];
        end
    end

    // stage 2
    logic            r_v2;
    t_item           r_it2;
    logic [F1_W-1:0] r_fy2, r_fx2;
    logic            r_py2, r_px2;
    logic            r_ex2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_it2 <= r_it1;
        r_fy2 <= fy;
        r_fx2 <= fx;
        r_py2 <= by[0];
        r_px2 <= bx[0];
        r_ex2 <= exact;
    end

    // stage 3: weights, neighbor order 00, 10, 01, 11
    logic             r_v3;
    t_item            r_it3;
    logic [W_W-1:0]   r_w [4];
    logic [PIX_W-1:0] r_p [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_it3  <= r_it2;
        r_w[0] <= W_W'(ONE - r_fx2) * W_W'(ONE - r_fy2);
        r_w[1] <= W_W'(ONE - r_fx2) * W_W'(r_fy2);
        r_w[2] <= W_W'(r_fx2) * W_W'(ONE - r_fy2);
        r_w[3] <= W_W'(r_fx2) * W_W'(r_fy2);
        // on an exact grid hit, drop every neighbor but the base one
        r_p[0] <= q[{r_py2, r_px2}];
        r_p[1] <= r_ex2 ? '0 : q[{!r_py2, r_px2}];
        r_p[2] <= r_ex2 ? '0 : q[{r_py2, !r_px2}];
        r_p[3] <= r_ex2 ? '0 : q[{!r_py2, !r_px2}];
    end

    // stage 4
    logic            r_v4;
    t_item           r_it4;
    logic [PR_W-1:0] r_prod [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        r_it4 <= r_it3;
        for (int k = 0; k < 4; k++) begin
            r_prod[k] <= PR_W'(r_w[k]) * PR_W'(r_p[k]);
        end
    end

    // stage 5
    logic [SUM_W-1:0] sum;
    logic             r_done;
    logic [PIX_W-1:0] r_pix;
    t_item            r_it5;

    assign sum = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1])
               + SUM_W'(r_prod[2]) + SUM_W'(r_prod[3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_v4 && (r_it4.is_req == REQ_PIXEL);
        end
        r_it5 <= r_it4;
        r_pix <= r_it4.flag ? '0 : sum[2*FRAC_BITS +: PIX_W];
    end

    assign o_done         = r_done;
    assign o_interp_pixel = r_pix;
    assign o_res_row      = r_it5.row;
    assign o_res_col      = r_it5.col;
    assign o_range_error  = r_it5.flag;

    a_req_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_it1.is_req == REQ_PIXEL) |-> ##4 o_done)
        else $error("request lost in pipeline");
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_it1.is_req == REQ_LOAD) |-> ##4 !o_done)
        else $error("load produced a result");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_range_error) |-> o_interp_pixel == '0)
        else $error("range error with nonzero pixel");

endmodule

// File: rtl/bilinear_image_scaler_core.sv
// Top level of the bilinear image scaler core.
// Accepts one word per clock (load or pixel request) while busy is low; busy
// rises only if the front register and the two-entry queue are both occupied,
// which the free-running back end never allows in steady state. A request
// returns its result with o_done after the queue hands it to the back end
// and it passes the multiply, bank read, weight, product and sum stages.
// The frame store is four banks split by row and column parity, so the four
// neighbors are read in the same cycle. Results cannot be held off. Write
// configuration only while no request is in flight.
module bilinear_image_scaler_core #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int FRAC_BITS      = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_req_type,
    input  logic [bis_pkg::COORD_W-1:0] i_pix_row,
    input  logic [bis_pkg::COORD_W-1:0] i_pix_col,
    input  logic [bis_pkg::PIX_W-1:0]   i_pixel_in,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bis_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [bis_pkg::INV_W-1:0]   i_cfg_data,
    output logic                        o_done,
    output logic [bis_pkg::PIX_W-1:0]   o_interp_pixel,
    output logic [bis_pkg::COORD_W-1:0] o_res_row,
    output logic [bis_pkg::COORD_W-1:0] o_res_col,
    output logic                        o_range_error
);
    import bis_pkg::*;

    t_cfg  r_cfg;
    logic  push, full, q_valid, accept;
    t_item f_item, q_item;

    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width  <= 9'd256;
            r_cfg.src_height <= 9'd256;
            r_cfg.out_width  <= 13'd256;
            r_cfg.out_height <= 13'd256;
            r_cfg.inv_scale  <= 21'd65536;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SRC_WIDTH:  r_cfg.src_width  <= i_cfg_data[8:0];
                REG_SRC_HEIGHT: r_cfg.src_height <= i_cfg_data[8:0];
                REG_OUT_WIDTH:  r_cfg.out_width  <= i_cfg_data[SIZE_W-1:0];
                REG_OUT_HEIGHT: r_cfg.out_height <= i_cfg_data[SIZE_W-1:0];
                REG_INV_SCALE:  r_cfg.inv_scale  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    bis_front #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req_type (i_req_type),
        .i_pix_row  (i_pix_row),
        .i_pix_col  (i_pix_col),
        .i_pixel_in (i_pixel_in),
        .i_cfg      (r_cfg),
        .i_full     (full),
        .o_push     (push),
        .o_item     (f_item),
        .o_busy     (busy)
    );

    bis_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    bis_back #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .FRAC_BITS      (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_item         (q_item),
        .i_cfg          (r_cfg),
        .o_done         (o_done),
        .o_interp_pixel (o_interp_pixel),
        .o_res_row      (o_res_row),
        .o_res_col      (o_res_col),
        .o_range_error  (o_range_error)
    );

endmodule

// File: test/tb.sv
// Testbench for the bilinear image scaler core: directed and random loads and pixel requests.
`timescale 1ns / 100ps

module tb;
    import bis_pkg::*;

    localparam int MAXW = 256;
    localparam int MAXH = 256;
    localparam int FB   = 16;
    localparam longint ONE = 64'd1 << FB;

    typedef struct packed {
        logic [PIX_W-1:0]   pix;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               err;
    } t_pixel_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_req_type = REQ_LOAD;
    logic [COORD_W-1:0]   i_pix_row = '0;
    logic [COORD_W-1:0]   i_pix_col = '0;
    logic [PIX_W-1:0]     i_pixel_in = '0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [IDX_W-1:0]     i_cfg_index = '0;
    logic [INV_W-1:0]     i_cfg_data = '0;
    logic                 o_done;
    logic [PIX_W-1:0]     o_interp_pixel;
    logic [COORD_W-1:0]   o_res_row;
    logic [COORD_W-1:0]   o_res_col;
    logic                 o_range_error;

    logic [7:0]           frame_img [MAXW*MAXH];
    bit                   written [MAXW*MAXH];
    int unsigned          cfg_sw, cfg_sh, cfg_ow, cfg_oh, cfg_inv;
    t_pixel_result        pending_pixels [$];
    int                   mismatches = 0;
    int                   burst_left = 0;

    bilinear_image_scaler_core i_dut (.*);

    always #2 i_clk = ~i_clk;

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic int unsigned clamp_dim(input int unsigned v);
        if (v < 2) return 2;
        if (v > 256) return 256;
        return v;
    endfunction

    function automatic longint pixel_at(input int unsigned r, input int unsigned c);
        return longint'(frame_img[r*MAXW + c]);
    endfunction

    function automatic t_pixel_result predict_pixel(input int unsigned r, input int unsigned c);
        t_pixel_result res;
        int unsigned sw, sh, iy, ix, by, bx;
        longint py, px, fy, fx, sum;
        res.row = COORD_W'(r);
        res.col = COORD_W'(c);
        res.err = 1'b0;
        res.pix = '0;
        if (r >= cfg_oh || c >= cfg_ow) begin
            res.err = 1'b1;
            return res;
        end
        sw = clamp_dim(cfg_sw);
        sh = clamp_dim(cfg_sh);
        py = longint'(r) * cfg_inv;
        px = longint'(c) * cfg_inv;
        fy = py & (ONE - 1);
        fx = px & (ONE - 1);
        iy = ((py >> FB) > sh - 1) ? sh - 1 : int'(py >> FB);
        ix = ((px >> FB) > sw - 1) ? sw - 1 : int'(px >> FB);
        by = iy;
        bx = ix;
        if (fy == 0 && fx == 0) begin
            res.pix = PIX_W'(pixel_at(iy, ix));
            return res;
        end
        if (iy == sh - 1) begin
            fy = ONE;
            by = sh - 2;
        end
        if (ix == sw - 1) begin
            fx = ONE;
            bx = sw - 2;
        end
        sum = (ONE - fx) * (ONE - fy) * pixel_at(by, bx)
            + (ONE - fx) * fy * pixel_at(by + 1, bx)
            + fx * (ONE - fy) * pixel_at(by, bx + 1)
            + fx * fy * pixel_at(by + 1, bx + 1);
        res.pix = PIX_W'(sum >> (2 * FB));
        return res;
    endfunction

    // hold off in bursts with random gaps
    task automatic sender_gap();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_word(input logic rt, input int unsigned r, input int unsigned c,
                             input int unsigned p);
        sender_gap();
        start      <= 1'b1;
        i_req_type <= rt;
        i_pix_row  <= COORD_W'(r);
        i_pix_col  <= COORD_W'(c);
        i_pixel_in <= PIX_W'(p);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (rt == REQ_LOAD) begin
            if (r < MAXH && c < MAXW) begin
                frame_img[r*MAXW + c] = 8'(p);
                written[r*MAXW + c] = 1'b1;
            end
        end else begin
            pending_pixels.push_back(predict_pixel(r, c));
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel_result exp_res;
        if (i_rst_n && o_done) begin
            if (pending_pixels.size() == 0) begin
                report("result with none expected");
            end else begin
                exp_res = pending_pixels.pop_front();
                if (o_interp_pixel !== exp_res.pix)
                    report($sformatf("pixel %0d exp %0d", o_interp_pixel, exp_res.pix));
                if (o_res_row !== exp_res.row)
                    report($sformatf("row %0d exp %0d", o_res_row, exp_res.row));
                if (o_res_col !== exp_res.col)
                    report($sformatf("col %0d exp %0d", o_res_col, exp_res.col));
                if (o_range_error !== exp_res.err)
                    report($sformatf("range_error %0b exp %0b", o_range_error, exp_res.err));
            end
        end
    end

    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (pending_pixels.size() != 0 && guard < 10000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= INV_W'(val);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_SRC_WIDTH:  cfg_sw = val & 9'h1FF;
            REG_SRC_HEIGHT: cfg_sh = val & 9'h1FF;
            REG_OUT_WIDTH:  cfg_ow = val & 13'h1FFF;
            REG_OUT_HEIGHT: cfg_oh = val & 13'h1FFF;
            REG_INV_SCALE:  cfg_inv = val & 21'h1FFFFF;
            default: ;
        endcase
    endtask

    task automatic set_scaling(input int unsigned sw, input int unsigned sh,
                               input int unsigned ow, input int unsigned oh,
                               input int unsigned inv);
        drain();
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_OUT_WIDTH, ow);
        write_reg(REG_OUT_HEIGHT, oh);
        write_reg(REG_INV_SCALE, inv);
        i_cfg_valid <= 1'b0;
    endtask

    // a request reads only neighbors inside the clamped source size
    function automatic bit area_written(input int unsigned sw, input int unsigned sh);
        for (int r = 0; r < clamp_dim(sh); r++)
            for (int c = 0; c < clamp_dim(sw); c++)
                if (!written[r*MAXW + c]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic load_block(input int unsigned h, input int unsigned w);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                send_word(REQ_LOAD, r, c, $urandom_range(0, 255));
    endtask

    task automatic test_directed();
        load_block(4, 4);
        send_word(REQ_LOAD, 0, 0, 0);
        send_word(REQ_LOAD, 3, 3, 255);
        send_word(REQ_LOAD, 4095, 4095, 8'hAA);
        send_word(REQ_LOAD, 300, 2, 8'h55);
        send_word(REQ_LOAD, 255, 255, 8'hFF);
        set_scaling(4, 4, 8, 8, 32768);
        send_word(REQ_PIXEL, 0, 0, 0);
        send_word(REQ_PIXEL, 1, 1, 0);
        send_word(REQ_PIXEL, 2, 4, 0);
        send_word(REQ_PIXEL, 7, 7, 0);
        send_word(REQ_PIXEL, 6, 3, 0);
        send_word(REQ_PIXEL, 8, 0, 255);
        send_word(REQ_PIXEL, 0, 8, 0);
        send_word(REQ_PIXEL, 4095, 4095, 0);
        set_scaling(4, 4, 4096, 4096, 2097151);
        send_word(REQ_PIXEL, 1, 1, 0);
        send_word(REQ_PIXEL, 4095, 4095, 0);
        set_scaling(0, 1, 0, 3, 65536);
        send_word(REQ_PIXEL, 0, 0, 0);
        set_scaling(2, 2, 1, 1, 0);
        send_word(REQ_PIXEL, 0, 0, 0);
        set_scaling(4, 4, 16, 16, 4096);
        send_word(REQ_PIXEL, 15, 15, 0);
        send_word(REQ_PIXEL, 5, 11, 0);
    endtask

    task automatic test_random_frames();
        int unsigned sw, sh, ow, oh, inv;
        int n;
        n = 0;
        while (n < 1500) begin
            sw = $urandom_range(2, 24);
            sh = $urandom_range(2, 24);
            if ($urandom_range(0, 9) == 0) begin
                sw = $urandom_range(257, 511);
                sh = 2;
            end
            inv = $urandom_range(0, 3) == 0 ? $urandom_range(4096, 2097151)
                                            : $urandom_range(4096, 200000);
            ow = $urandom_range(1, 4096);
            oh = $urandom_range(1, 4096);
            set_scaling(sw, sh, ow, oh, inv);
            if (!area_written(sw, sh)) begin
                load_block(clamp_dim(sh), clamp_dim(sw));
                n += clamp_dim(sh) * clamp_dim(sw);
            end
            repeat ($urandom_range(40, 120)) begin
                case ($urandom_range(0, 9))
                    0: send_word(REQ_LOAD, $urandom_range(0, 4095), $urandom_range(0, 4095),
                                 $urandom_range(0, 255));
                    1: send_word(REQ_LOAD, $urandom_range(0, clamp_dim(sh) - 1),
                                 $urandom_range(0, clamp_dim(sw) - 1), $urandom_range(0, 255));
                    2: send_word(REQ_PIXEL, $urandom_range(0, 4095), $urandom_range(0, 4095),
                                 $urandom_range(0, 255));
                    default: send_word(REQ_PIXEL,
                                 $urandom_range(0, oh > 64 ? 64 : oh - 1),
                                 $urandom_range(0, ow > 64 ? 64 : ow - 1), 0);
                endcase
                n++;
            end
        end
    endtask

    initial begin
        cfg_sw = 256;
        cfg_sh = 256;
        cfg_ow = 256;
        cfg_oh = 256;
        cfg_inv = 65536;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_frames();
        drain();
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// File: files.f
rtl/bis_pkg.sv
rtl/bis_front.sv
rtl/bis_fifo.sv
rtl/bis_back.sv
rtl/bilinear_image_scaler_core.sv
test/tb.sv
